### src/assert_macros.svh
// Assertion helpers for the triple-buffer exchange.
// Every check is sampled on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that a condition implies another condition in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that a condition implies another condition in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/tbx_pkg.sv
package tbx_pkg;

  // Sizing of the buffer pool.
  localparam int NUM_BUFFERS = 3;
  localparam int READER_BITS = 8;
  localparam int SEQ_BITS    = 32;

  // Derived widths.
  localparam int SLOT_W    = $clog2(NUM_BUFFERS);
  localparam int SEQ_CMP_W = (SEQ_BITS > 32) ? SEQ_BITS : 32;

  // Fixed field widths of the stream words.
  localparam int CMD_W       = 3;
  localparam int BIDX_W      = 2;
  localparam int STAMP_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int OUT_SEQ_W   = 32;
  localparam int S_DATA_W    = 72;
  localparam int M_DATA_W    = 72;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_BEGIN_WRITE    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUBLISH        = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ACQUIRE_LATEST = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ACQUIRE_IF_NEW = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RELEASE        = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;
  localparam logic [STATUS_W-1:0] ST_LIMIT     = 2'd3;

  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [READER_BITS-1:0] count_t;
  typedef logic [SEQ_BITS-1:0]    seq_t;
  typedef logic [STAMP_W-1:0]     stamp_t;

endpackage

### src/triple_buffer_exchange_top.sv
// A command word is accepted into the input register and leaves through the result register.
// Throughput: one command word per cycle unless m_tready stalls; each command is resolved in
// a single pass between the two registers, with the pool state updated on that edge.
// Reset (rst, synchronous, active high) empties both registers, clears all reader counts,
// sequences and stamps, and sets the write pointer and the published buffer to buffer 0.
module triple_buffer_exchange_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // Fields from bit 0: command.
  input  logic [tbx_pkg::CMD_W-1:0]     s_tuser,
  // Fields from bit 0: buffer_index, last_seen_sequence, timestamp_ms, zero fill.
  input  logic [tbx_pkg::S_DATA_W-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // Fields from bit 0: status, granted_index, granted_sequence, granted_stamp_ms, zero fill.
  output logic [tbx_pkg::M_DATA_W-1:0]  m_tdata
);
  import tbx_pkg::*;

  // Input register.
  logic                  in_valid;
  logic [CMD_W-1:0]      in_cmd;
  logic [BIDX_W-1:0]     in_bidx;
  logic [31:0]           in_last;
  stamp_t                in_stamp;

  // Result register.
  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic [BIDX_W-1:0]     out_index;
  logic [OUT_SEQ_W-1:0]  out_seq;
  stamp_t                out_stamp;

  // Pool state.
  slot_t  write_pointer;
  slot_t  published_slot;
  seq_t   latest_sequence;
  count_t reader_count [NUM_BUFFERS];
  seq_t   slot_sequence [NUM_BUFFERS];
  stamp_t slot_stamp [NUM_BUFFERS];

  // Next values and write strobes produced by the command logic.
  slot_t                write_pointer_next;
  slot_t                published_slot_next;
  seq_t                 latest_sequence_next;
  logic                 cnt_we;
  count_t               cnt_val;
  logic                 slot_we;
  slot_t                slot_addr;
  seq_t                 slot_seq_val;
  stamp_t               slot_stamp_val;
  logic [STATUS_W-1:0]  res_status;
  slot_t                res_slot;
  seq_t                 res_seq;
  stamp_t               res_stamp;

  logic                 advance;
  logic                 fire;
  logic                 bidx_ok;
  slot_t                bidx_slot;
  slot_t                sel_slot;
  count_t               sel_count;
  seq_t                 sel_seq;
  stamp_t               sel_stamp;
  seq_t                 seq_inc;
  seq_t                 seq_new;
  logic                 seen_same;
  logic [NUM_BUFFERS-1:0] free_vec;
  logic                 scan_found;
  slot_t                scan_slot;
  logic [SLOT_W:0]      cand_sum;
  slot_t                cand;
  logic [SLOT_W:0]      wrap_sum;
  slot_t                wrap_next;

  // Handshake: the result register drains or is empty, then the input register moves on.
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign fire     = in_valid && advance;

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_stamp, out_seq, out_index, out_status};

  // Input register load.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_cmd   <= s_tuser;
      in_bidx  <= s_tdata[1:0];
      in_last  <= s_tdata[33:2];
      in_stamp <= s_tdata[65:34];
    end
  end

  // Index decode and the single read port shared by acquire and release.
  assign bidx_ok   = (32'(in_bidx) < NUM_BUFFERS);
  assign bidx_slot = bidx_ok ? SLOT_W'(in_bidx) : '0;
  assign sel_slot  = (in_cmd == CMD_RELEASE) ? bidx_slot : published_slot;
  assign sel_count = reader_count[sel_slot];
  assign sel_seq   = slot_sequence[sel_slot];
  assign sel_stamp = slot_stamp[sel_slot];

  // Next sequence number skips zero on wrap.
  assign seq_inc   = latest_sequence + SEQ_BITS'(1);
  assign seq_new   = (seq_inc == '0) ? SEQ_BITS'(1) : seq_inc;
  assign seen_same = (SEQ_CMP_W'(latest_sequence) == SEQ_CMP_W'(in_last));

  // Write pointer after a publish moves one past the published buffer.
  assign wrap_sum  = (SLOT_W+1)'(bidx_slot) + (SLOT_W+1)'(1);
  assign wrap_next = (32'(wrap_sum) >= NUM_BUFFERS) ? '0 : wrap_sum[SLOT_W-1:0];

  // A buffer is free when it is not published and no reader holds it.
  always_comb begin
    for (int j = 0; j < NUM_BUFFERS; j++) begin
      free_vec[j] = (SLOT_W'(j) != published_slot) && (reader_count[j] == '0);
    end
  end

  // Round-robin pick starting at the write pointer.
  always_comb begin
    scan_found = 1'b0;
    scan_slot  = '0;
    cand_sum   = '0;
    cand       = '0;
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      cand_sum = (SLOT_W+1)'(write_pointer) + (SLOT_W+1)'(i);
      if (32'(cand_sum) >= NUM_BUFFERS) begin
        cand_sum = cand_sum - (SLOT_W+1)'(NUM_BUFFERS);
      end
      cand = cand_sum[SLOT_W-1:0];
      if (!scan_found && free_vec[cand]) begin
        scan_found = 1'b1;
        scan_slot  = cand;
      end
    end
  end

  // Command resolution.
  always_comb begin
    write_pointer_next   = write_pointer;
    published_slot_next  = published_slot;
    latest_sequence_next = latest_sequence;
    cnt_we         = 1'b0;
    cnt_val        = sel_count;
    slot_we        = 1'b0;
    slot_addr      = bidx_slot;
    slot_seq_val   = '0;
    slot_stamp_val = '0;
    res_status     = ST_OK;
    res_slot       = sel_slot;
    res_seq        = sel_seq;
    res_stamp      = sel_stamp;
    case (in_cmd)
      CMD_BEGIN_WRITE: begin
        if (scan_found) begin
          write_pointer_next = scan_slot;
          slot_we   = 1'b1;
          slot_addr = scan_slot;
          res_slot  = scan_slot;
          res_seq   = '0;
          res_stamp = '0;
        end else begin
          res_status = ST_NONE;
        end
      end
      CMD_PUBLISH: begin
        if (bidx_ok) begin
          slot_we              = 1'b1;
          slot_addr            = bidx_slot;
          slot_seq_val         = seq_new;
          slot_stamp_val       = in_stamp;
          published_slot_next  = bidx_slot;
          latest_sequence_next = seq_new;
          write_pointer_next   = wrap_next;
          res_slot  = bidx_slot;
          res_seq   = seq_new;
          res_stamp = in_stamp;
        end else begin
          res_status = ST_BAD_INDEX;
        end
      end
      CMD_ACQUIRE_LATEST, CMD_ACQUIRE_IF_NEW: begin
        if (latest_sequence == '0 || (in_cmd == CMD_ACQUIRE_IF_NEW && seen_same)) begin
          res_status = ST_NONE;
        end else if (sel_count == '1) begin
          res_status = ST_LIMIT;
        end else begin
          cnt_we  = 1'b1;
          cnt_val = sel_count + READER_BITS'(1);
        end
      end
      CMD_RELEASE: begin
        if (!bidx_ok) begin
          res_status = ST_BAD_INDEX;
        end else if (sel_count == '0) begin
          res_status = ST_LIMIT;
        end else begin
          cnt_we  = 1'b1;
          cnt_val = sel_count - READER_BITS'(1);
        end
      end
      default: begin
        res_status = ST_NONE;
      end
    endcase
  end

  // Pool state update, on the same edge that loads the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer   <= '0;
      published_slot  <= '0;
      latest_sequence <= '0;
      for (int k = 0; k < NUM_BUFFERS; k++) begin
        reader_count[k]  <= '0;
        slot_sequence[k] <= '0;
        slot_stamp[k]    <= '0;
      end
    end else if (fire) begin
      write_pointer   <= write_pointer_next;
      published_slot  <= published_slot_next;
      latest_sequence <= latest_sequence_next;
      if (cnt_we) begin
        reader_count[sel_slot] <= cnt_val;
      end
      if (slot_we) begin
        slot_sequence[slot_addr] <= slot_seq_val;
        slot_stamp[slot_addr]    <= slot_stamp_val;
      end
    end
  end

  // Result register; a failed command returns zeros beside its status.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (fire) begin
      out_status <= res_status;
      if (res_status == ST_OK) begin
        out_index <= BIDX_W'(res_slot);
        out_seq   <= OUT_SEQ_W'(res_seq);
        out_stamp <= res_stamp;
      end else begin
        out_index <= '0;
        out_seq   <= '0;
        out_stamp <= '0;
      end
    end
  end

  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_ptr_range, (32'(write_pointer) < NUM_BUFFERS) && (32'(published_slot) < NUM_BUFFERS), "buffer pointer out of range")
  `ASSERT_SAME(a_fail_zero, out_valid && out_status != ST_OK, out_index == '0 && out_seq == '0 && out_stamp == '0, "failed result carries data")
  `ASSERT_NEXT(a_publish_seq, fire && in_cmd == CMD_PUBLISH && bidx_ok, latest_sequence != '0 && out_seq == OUT_SEQ_W'(latest_sequence), "publish did not advance the sequence")
  `ASSERT_NEXT(a_grant_count, fire && cnt_we && in_cmd != CMD_RELEASE, reader_count[$past(sel_slot)] != '0, "acquire left a zero reader count")
endmodule

### verif/exchange_scoreboard_pkg.sv
`timescale 1ns / 100ps

package exchange_scoreboard_pkg;
  import tbx_pkg::*;

  // Command codes past release are unused and must be rejected.
  localparam logic [CMD_W-1:0]  CMD_FIRST_UNUSED = 3'd5;
  // First buffer index that does not name a buffer.
  localparam logic [BIDX_W-1:0] BAD_SLOT         = 2'd3;

  // One result word, split into its fields.
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [BIDX_W-1:0]    index;
    logic [OUT_SEQ_W-1:0] seq;
    logic [STAMP_W-1:0]   stamp;
  } exchange_reply_t;

  class exchange_scoreboard;
    logic [BIDX_W-1:0] write_ptr;
    logic [BIDX_W-1:0] pub_slot;
    logic [BIDX_W-1:0] last_write_slot;
    seq_t              latest_seq;
    count_t            readers[NUM_BUFFERS];
    seq_t              slot_seq[NUM_BUFFERS];
    stamp_t            slot_stamp[NUM_BUFFERS];
    exchange_reply_t   expected_replies[$];
    int                failures;

    function new();
      write_ptr = '0;
      pub_slot = '0;
      last_write_slot = 2'd1;
      latest_seq = '0;
      failures = 0;
      for (int k = 0; k < NUM_BUFFERS; k++) begin
        readers[k] = '0;
        slot_seq[k] = '0;
        slot_stamp[k] = '0;
      end
    endfunction

    // A successful reply describes the named buffer.
    function exchange_reply_t grant(int s);
      exchange_reply_t r;
      r.status = ST_OK;
      r.index = BIDX_W'(s);
      r.seq = OUT_SEQ_W'(slot_seq[s]);
      r.stamp = slot_stamp[s];
      return r;
    endfunction

    // A reader takes the published buffer unless its count is saturated.
    function exchange_reply_t grant_reader();
      exchange_reply_t r;
      r = '0;
      if (readers[pub_slot] == '1) begin
        r.status = ST_LIMIT;
      end else begin
        readers[pub_slot]++;
        r = grant(pub_slot);
      end
      return r;
    endfunction

    // Updates the pool for one accepted command word and queues its reply.
    function void note_command(logic [CMD_W-1:0] cmd, logic [BIDX_W-1:0] idx,
                               logic [31:0] last_seen, logic [STAMP_W-1:0] stamp);
      exchange_reply_t r;
      int              cand;
      bit              found;
      seq_t            nxt;
      r = '0;
      r.status = ST_NONE;
      found = 0;
      case (cmd)
        CMD_BEGIN_WRITE: begin
          for (int k = 0; k < NUM_BUFFERS; k++) begin
            cand = (int'(write_ptr) + k) % NUM_BUFFERS;
            if (!found && cand != int'(pub_slot) && readers[cand] == '0) begin
              found = 1;
              write_ptr = BIDX_W'(cand);
              last_write_slot = BIDX_W'(cand);
              slot_seq[cand] = '0;
              slot_stamp[cand] = '0;
              r = grant(cand);
            end
          end
        end
        CMD_PUBLISH: begin
          if (int'(idx) >= NUM_BUFFERS) begin
            r.status = ST_BAD_INDEX;
          end else begin
            // Sequence numbers skip zero when they wrap.
            nxt = latest_seq + 1'b1;
            if (nxt == '0) nxt = 1;
            slot_seq[idx] = nxt;
            slot_stamp[idx] = stamp;
            pub_slot = idx;
            latest_seq = nxt;
            write_ptr = BIDX_W'((int'(idx) + 1) % NUM_BUFFERS);
            r = grant(idx);
          end
        end
        CMD_ACQUIRE_LATEST: begin
          if (latest_seq != '0) r = grant_reader();
        end
        CMD_ACQUIRE_IF_NEW: begin
          if (latest_seq != '0 && SEQ_CMP_W'(latest_seq) != SEQ_CMP_W'(last_seen))
            r = grant_reader();
        end
        CMD_RELEASE: begin
          if (int'(idx) >= NUM_BUFFERS) begin
            r.status = ST_BAD_INDEX;
          end else if (readers[idx] == '0) begin
            r.status = ST_LIMIT;
          end else begin
            readers[idx]--;
            r = grant(idx);
          end
        end
        default: ;
      endcase
      expected_replies.push_back(r);
    endfunction

    // Compares one result word with the oldest expected reply.
    function void check_result(logic [M_DATA_W-1:0] word);
      exchange_reply_t exp_r;
      exchange_reply_t got;
      got.status = word[1:0];
      got.index = word[3:2];
      got.seq = word[35:4];
      got.stamp = word[67:36];
      if (expected_replies.size() == 0) begin
        $error("result word with no command waiting: %h", word);
        failures++;
        return;
      end
      exp_r = expected_replies.pop_front();
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, actual %0d", exp_r.status, got.status);
        failures++;
      end
      if (got.index !== exp_r.index) begin
        $error("granted_index: expected %0d, actual %0d", exp_r.index, got.index);
        failures++;
      end
      if (got.seq !== exp_r.seq) begin
        $error("granted_sequence: expected %0d, actual %0d", exp_r.seq, got.seq);
        failures++;
      end
      if (got.stamp !== exp_r.stamp) begin
        $error("granted_stamp_ms: expected %0d, actual %0d", exp_r.stamp, got.stamp);
        failures++;
      end
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    // Picks a buffer that some reader holds, or the fallback if none is held.
    function logic [BIDX_W-1:0] held_slot(logic [BIDX_W-1:0] fallback);
      int start;
      int s;
      start = $urandom_range(0, NUM_BUFFERS - 1);
      for (int k = 0; k < NUM_BUFFERS; k++) begin
        s = (start + k) % NUM_BUFFERS;
        if (readers[s] != '0) return BIDX_W'(s);
      end
      return fallback;
    endfunction
  endclass

endpackage

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tbx_pkg::*;
  import exchange_scoreboard_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  // Fields from bit 0: command.
  logic [CMD_W-1:0]    s_tuser = '0;
  // Fields from bit 0: buffer_index, last_seen_sequence, timestamp_ms, zero fill.
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // Fields from bit 0: status, granted_index, granted_sequence, granted_stamp_ms, zero fill.
  logic [M_DATA_W-1:0] m_tdata;

  exchange_scoreboard pool;
  bit                 idling = 1'b1;
  bit                 hold_req = 1'b0;

  triple_buffer_exchange_top uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser(s_tuser),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // Offers one command word and returns at the falling edge after it is taken.
  task automatic send_word(logic [CMD_W-1:0] cmd, logic [BIDX_W-1:0] idx,
                           logic [31:0] last_seen, logic [STAMP_W-1:0] stamp);
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {6'b0, stamp, last_seen, idx};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Sender goes quiet for a burst of cycles.
  task automatic sender_gap(int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Mostly well-formed writer and reader traffic, with some invalid commands mixed in.
  task automatic send_random_command();
    logic [CMD_W-1:0]  cmd;
    logic [BIDX_W-1:0] idx;
    logic [31:0]       seen;
    int                pick;
    pick = $urandom_range(0, 99);
    idx = BIDX_W'($urandom_range(0, 3));
    seen = $urandom();
    if (pick < 20) begin
      cmd = CMD_BEGIN_WRITE;
    end else if (pick < 40) begin
      cmd = CMD_PUBLISH;
      if ($urandom_range(0, 9) < 7) idx = pool.last_write_slot;
    end else if (pick < 55) begin
      cmd = CMD_ACQUIRE_LATEST;
    end else if (pick < 67) begin
      cmd = CMD_ACQUIRE_IF_NEW;
      case ($urandom_range(0, 3))
        0, 1: seen = 32'(pool.latest_seq);
        2: seen = '0;
        default: ;
      endcase
    end else if (pick < 95) begin
      cmd = CMD_RELEASE;
      if ($urandom_range(0, 4) != 0) idx = pool.held_slot(idx);
    end else begin
      cmd = CMD_FIRST_UNUSED + CMD_W'($urandom_range(0, 2));
    end
    send_word(cmd, idx, seen, $urandom());
  endtask

  // Drives one buffer's reader count up to its limit and back down past zero.
  task automatic saturate_readers();
    logic [BIDX_W-1:0] s;
    s = BIDX_W'($urandom_range(0, NUM_BUFFERS - 1));
    send_word(CMD_PUBLISH, s, $urandom(), $urandom());
    for (int k = 0; k < (1 << READER_BITS); k++)
      send_word(CMD_ACQUIRE_LATEST, BIDX_W'($urandom_range(0, 3)), $urandom(), $urandom());
    for (int k = 0; k <= (1 << READER_BITS); k++)
      send_word(CMD_RELEASE, s, $urandom(), $urandom());
  endtask

  // Watch both handshakes; the command is noted before any result of the same edge.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      pool.note_command(s_tuser, s_tdata[1:0], s_tdata[33:2], s_tdata[65:34]);
    if (!rst && m_tvalid && m_tready)
      pool.check_result(m_tdata);
  end

  // Result side: random stalls, open stretches, and one long hold-off on request.
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (80) @(negedge clk);
        hold_req = 1'b0;
      end else if (idling && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk);
      end
    end
  end

  // Main sequence: reset, directed cases, random traffic, drain, verdict.
  initial begin
    pool = new();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Nothing published yet, bad indexes, empty release, unused codes.
    send_word(CMD_ACQUIRE_LATEST, 2'd0, 32'd0, 32'd0);
    send_word(CMD_ACQUIRE_IF_NEW, 2'd0, 32'd0, 32'd0);
    send_word(CMD_BEGIN_WRITE, 2'd0, 32'd0, 32'd0);
    send_word(CMD_PUBLISH, BAD_SLOT, 32'd0, 32'hFFFF_FFFF);
    send_word(CMD_RELEASE, BAD_SLOT, 32'd0, 32'd0);
    send_word(CMD_RELEASE, 2'd0, 32'd0, 32'd0);
    for (int k = 0; k < 3; k++)
      send_word(CMD_FIRST_UNUSED + CMD_W'(k), BAD_SLOT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Publish and read back, with the already-seen sequence skipped.
    send_word(CMD_PUBLISH, 2'd1, 32'd0, 32'hFFFF_FFFF);
    send_word(CMD_ACQUIRE_IF_NEW, 2'd0, 32'd1, 32'd0);
    send_word(CMD_ACQUIRE_IF_NEW, 2'd0, 32'hFFFF_FFFF, 32'd0);
    send_word(CMD_ACQUIRE_LATEST, 2'd0, 32'd0, 32'd0);
    send_word(CMD_BEGIN_WRITE, 2'd0, 32'd0, 32'd0);
    send_word(CMD_PUBLISH, 2'd2, 32'd0, 32'd0);
    send_word(CMD_ACQUIRE_LATEST, 2'd0, 32'd0, 32'd0);
    send_word(CMD_PUBLISH, 2'd0, 32'd0, 32'h5A5A_A5A5);
    // Every other buffer is held by readers, so the writer gets nothing.
    send_word(CMD_BEGIN_WRITE, 2'd0, 32'd0, 32'd0);
    send_word(CMD_RELEASE, 2'd1, 32'd0, 32'd0);
    send_word(CMD_RELEASE, 2'd1, 32'd0, 32'd0);
    send_word(CMD_RELEASE, 2'd1, 32'd0, 32'd0);
    send_word(CMD_BEGIN_WRITE, 2'd0, 32'd0, 32'd0);
    send_word(CMD_RELEASE, 2'd2, 32'd0, 32'd0);
    send_word(CMD_ACQUIRE_LATEST, BAD_SLOT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    for (int n = 0; n < 1110; n++) begin
      if (n == 300) saturate_readers();
      // The receiver holds off while commands keep coming.
      if (n == 550) hold_req = 1'b1;
      // The sender waits until every reply is back.
      if (n == 700) begin
        s_tvalid <= 1'b0;
        while (pool.pending() != 0) @(negedge clk);
      end
      if (n == 900) idling = 1'b0;
      if (idling && $urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 18));
      send_random_command();
    end
    s_tvalid <= 1'b0;

    while (pool.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pool.failures == 0 && pool.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog against a stuck handshake.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
